>>> rtl/core/haptic_effect_sequencer_defines.svh
// Assertion helpers used by the checker, hes_checker.
`ifndef HAPTIC_EFFECT_SEQUENCER_DEFINES_SVH
`define HAPTIC_EFFECT_SEQUENCER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define HES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define HES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/hes_pkg.sv
package hes_pkg;

  localparam int NUM_CLASSES    = 9;
  localparam int ROM_STEPS      = 6;
  localparam int STEP_LIMIT_DEF = 8;

  typedef logic [3:0] cls_t;
  typedef logic [1:0] str_t;
  typedef logic [1:0] src_t;
  typedef logic [8:0] ms_t;
  typedef logic [2:0] len_t;
  typedef logic [2:0] rom_pos_t;
  typedef logic [1:0] reg_idx_t;
  typedef logic [7:0] duty_t;

  typedef struct packed {
    cls_t cls;
    str_t str;
  } cmd_class_t;

  // effect classes
  localparam cls_t CLS_NONE    = 4'd0;
  localparam cls_t CLS_CLICK   = 4'd1;
  localparam cls_t CLS_TAP     = 4'd2;
  localparam cls_t CLS_PULSE   = 4'd3;
  localparam cls_t CLS_HEAVY   = 4'd4;
  localparam cls_t CLS_SHORT   = 4'd5;
  localparam cls_t CLS_LONG    = 4'd6;
  localparam cls_t CLS_DOUBLE  = 4'd7;
  localparam cls_t CLS_WARNING = 4'd8;

  // strength levels
  localparam str_t STR_LOW  = 2'd0;
  localparam str_t STR_MED  = 2'd1;
  localparam str_t STR_HIGH = 2'd2;

  // duty source of a pattern step
  localparam src_t SRC_ZERO = 2'd0;
  localparam src_t SRC_STR  = 2'd1;
  localparam src_t SRC_MED  = 2'd2;
  localparam src_t SRC_HIGH = 2'd3;

  // config register indexes
  localparam reg_idx_t REG_DUTY_LOW = 2'd0;
  localparam reg_idx_t REG_DUTY_MED = 2'd1;
  localparam reg_idx_t REG_DUTY_HI  = 2'd2;

  localparam duty_t DUTY_LOW_RST = 8'd170;
  localparam duty_t DUTY_MED_RST = 8'd220;
  localparam duty_t DUTY_HI_RST  = 8'd255;

  localparam ms_t ELAPSED_MAX = 9'd511;

  // classification thresholds
  localparam logic [7:0]  AMP_MED_MIN     = 8'd85;
  localparam logic [7:0]  AMP_HIGH_MIN    = 8'd170;
  localparam logic [7:0]  AMP_HEAVY_MIN   = 8'd180;
  localparam logic [7:0]  AMP_DOUBLE_MIN  = 8'd220;
  localparam logic [7:0]  AMP_WARN_MIN    = 8'd200;
  localparam logic [15:0] DUR_CLICK_MAX   = 16'd30;
  localparam logic [15:0] DUR_TAP_MAX     = 16'd65;
  localparam logic [15:0] DUR_PULSE_MAX   = 16'd120;
  localparam logic [15:0] DUR_SHORT_MAX   = 16'd220;
  localparam logic [15:0] DUR_DOUBLE_MAX  = 16'd45;
  localparam logic [15:0] DUR_WARN_MIN    = 16'd350;

  function automatic len_t pat_len(cls_t c);
    len_t n;
    case (c)
      CLS_CLICK, CLS_TAP, CLS_PULSE, CLS_HEAVY, CLS_SHORT, CLS_LONG: n = 3'd2;
      CLS_DOUBLE:  n = 3'd4;
      CLS_WARNING: n = 3'd6;
      default:     n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic src_t pat_src(cls_t c, rom_pos_t p);
    src_t s;
    s = SRC_ZERO;
    case (c)
      CLS_CLICK, CLS_TAP, CLS_SHORT, CLS_LONG: if (p == 3'd0) s = SRC_STR;
      CLS_PULSE:   if (p == 3'd0) s = SRC_MED;
      CLS_HEAVY:   if (p == 3'd0) s = SRC_HIGH;
      CLS_DOUBLE:  if (!p[0] && p < 3'd4) s = SRC_HIGH;
      CLS_WARNING: if (!p[0] && p < 3'd6) s = SRC_HIGH;
      default:     s = SRC_ZERO;
    endcase
    return s;
  endfunction

  function automatic ms_t pat_time(cls_t c, rom_pos_t p);
    ms_t t;
    case (c)
      CLS_CLICK:   t = (p == 3'd0) ? 9'd25  : 9'd40;
      CLS_TAP:     t = 9'd50;
      CLS_PULSE:   t = (p == 3'd0) ? 9'd90  : 9'd60;
      CLS_HEAVY:   t = (p == 3'd0) ? 9'd120 : 9'd70;
      CLS_SHORT:   t = (p == 3'd0) ? 9'd170 : 9'd80;
      CLS_LONG:    t = (p == 3'd0) ? 9'd320 : 9'd100;
      CLS_DOUBLE:  t = !p[0] ? 9'd25  : ((p == 3'd1) ? 9'd70 : 9'd80);
      CLS_WARNING: t = !p[0] ? 9'd120 : ((p == 3'd5) ? 9'd100 : 9'd70);
      default:     t = 9'd1;
    endcase
    return t;
  endfunction

endpackage

>>> rtl/core/haptic_effect_sequencer.sv
// Haptic effect sequencer. Each input transfer is a rumble command
// (in_action = 1) or a 1 ms tick (in_action = 0), and each produces exactly
// one result transfer showing the motor duty, the playing flag, the effect
// class and the strength after that item. Items land in an input register
// at the input transfer edge and are applied to the sequencer state at the
// next edge on which the result slot is free; the state registers are
// themselves the result register, so a result passes the input register
// and then the state registers. The block sustains one item per cycle while
// out_ready stays high, set by the combinational state update (classify,
// pattern ROM lookup, elapsed compare). A new input is taken while a result
// waits for out_ready, as long as the input register is free. The duty
// registers (cfg_index 0 low, 1 medium, 2 high) are written with cfg_we and
// take effect for pattern steps that start after the write.
module haptic_effect_sequencer #(
  parameter int STEP_LIMIT = hes_pkg::STEP_LIMIT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_action,
  input  logic [7:0]          in_amplitude,
  input  logic [15:0]         in_duration_ms,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_motor_duty,
  output logic                out_playing,
  output logic [3:0]          out_effect_class,
  output logic [1:0]          out_strength_level,
  // config write port
  input  logic                cfg_we,
  input  hes_pkg::reg_idx_t   cfg_index,
  input  logic [7:0]          cfg_wdata
);
  import hes_pkg::*;

  // step position counter wide enough for STEP_LIMIT steps; PW+1 bits for
  // the incremented value and the length compare
  localparam int PW = $clog2(STEP_LIMIT);
  localparam logic [PW:0] STEP_LIMIT_W = (PW+1)'(STEP_LIMIT);
  localparam logic [PW:0] ROM_STEPS_W  = (PW+1)'(ROM_STEPS);

  // input register
  logic        in_vld_r;
  logic        act_r;
  logic [7:0]  amp_r;
  logic [15:0] dur_r;

  // config registers
  duty_t duty_low_r, duty_med_r, duty_hi_r;

  // sequencer state, doubles as result register
  logic          out_vld_r;
  cls_t          eff_r,   eff_nxt;
  str_t          str_r,   str_nxt;
  logic [PW-1:0] pos_r,   pos_nxt;
  ms_t           el_r,    el_nxt;
  logic          run_r,   run_nxt;
  duty_t         drive_r, drive_nxt;

  logic       adv;   // result slot free for a new result
  logic       proc;  // an item is applied this cycle

  cmd_class_t  cmd_cls;
  ms_t         el_inc;
  ms_t         step_tm;
  logic [PW:0] nxt_pos;
  logic [PW:0] len_w;
  logic [PW:0] steps;
  src_t        src_sel;
  str_t        str_sel;
  duty_t       duty_sel;

  assign adv      = !out_vld_r || out_ready;
  assign proc     = in_vld_r && adv;
  assign in_ready = !in_vld_r || adv;

  hes_classify u_classify (
    .amplitude   (amp_r),
    .duration_ms (dur_r),
    .cmd_cls     (cmd_cls)
  );

  // ---- step timing for the running pattern ----
  assign el_inc  = (el_r == ELAPSED_MAX) ? el_r : el_r + 9'd1;
  assign step_tm = ({1'b0, pos_r} < ROM_STEPS_W) ? pat_time(eff_r, pos_r[2:0]) : 9'd1;
  assign nxt_pos = {1'b0, pos_r} + {{PW{1'b0}}, 1'b1};
  assign len_w   = (PW+1)'(pat_len(eff_r));
  assign steps   = (len_w > STEP_LIMIT_W) ? STEP_LIMIT_W : len_w;

  // ---- duty of the step that starts now ----
  // a command starts step 0 of the new class with the new strength;
  // a tick that crosses a step boundary starts the next step
  always_comb begin
    if (act_r) begin
      src_sel = pat_src(cmd_cls.cls, 3'd0);
      str_sel = cmd_cls.str;
    end else begin
      src_sel = (nxt_pos < ROM_STEPS_W) ? pat_src(eff_r, nxt_pos[2:0]) : SRC_ZERO;
      str_sel = str_r;
    end
    case (src_sel)
      SRC_STR: begin
        case (str_sel)
          STR_LOW:  duty_sel = duty_low_r;
          STR_HIGH: duty_sel = duty_hi_r;
          default:  duty_sel = duty_med_r;
        endcase
      end
      SRC_MED:  duty_sel = duty_med_r;
      SRC_HIGH: duty_sel = duty_hi_r;
      default:  duty_sel = 8'd0;
    endcase
  end

  // ---- state update ----
  always_comb begin
    eff_nxt   = eff_r;
    str_nxt   = str_r;
    pos_nxt   = pos_r;
    el_nxt    = el_r;
    run_nxt   = run_r;
    drive_nxt = drive_r;
    if (act_r) begin
      // command: cancel whatever runs, start the new pattern
      eff_nxt   = cmd_cls.cls;
      str_nxt   = cmd_cls.str;
      pos_nxt   = '0;
      el_nxt    = '0;
      run_nxt   = 1'b1;
      drive_nxt = duty_sel;
    end else if (run_r) begin
      el_nxt = el_inc;
      if (el_inc >= step_tm) begin
        if (nxt_pos >= steps) begin
          // last step done: motor off, idle; class and strength stay
          pos_nxt   = '0;
          el_nxt    = '0;
          run_nxt   = 1'b0;
          drive_nxt = 8'd0;
        end else begin
          pos_nxt   = nxt_pos[PW-1:0];
          el_nxt    = '0;
          drive_nxt = duty_sel;
        end
      end
    end
    // tick while idle: nothing changes
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r <= in_action;
      amp_r <= in_amplitude;
      dur_r <= in_duration_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_low_r <= DUTY_LOW_RST;
      duty_med_r <= DUTY_MED_RST;
      duty_hi_r  <= DUTY_HI_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DUTY_LOW: duty_low_r <= cfg_wdata;
        REG_DUTY_MED: duty_med_r <= cfg_wdata;
        REG_DUTY_HI:  duty_hi_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      eff_r     <= CLS_NONE;
      str_r     <= STR_LOW;
      pos_r     <= '0;
      el_r      <= '0;
      run_r     <= 1'b0;
      drive_r   <= 8'd0;
    end else begin
      if (adv) begin
        out_vld_r <= in_vld_r;
      end
      if (proc) begin
        eff_r   <= eff_nxt;
        str_r   <= str_nxt;
        pos_r   <= pos_nxt;
        el_r    <= el_nxt;
        run_r   <= run_nxt;
        drive_r <= drive_nxt;
      end
    end
  end

  assign out_valid          = out_vld_r;
  assign out_motor_duty     = drive_r;
  assign out_playing        = run_r;
  assign out_effect_class   = eff_r;
  assign out_strength_level = str_r;

endmodule

>>> rtl/core/hes_classify.sv
module hes_classify (
  input  logic [7:0]              amplitude,
  input  logic [15:0]             duration_ms,
  output hes_pkg::cmd_class_t     cmd_cls
);
  import hes_pkg::*;

  cls_t cls;
  str_t str;

  always_comb begin
    if (amplitude < AMP_MED_MIN) begin
      str = STR_LOW;
    end else if (amplitude < AMP_HIGH_MIN) begin
      str = STR_MED;
    end else begin
      str = STR_HIGH;
    end

    if (duration_ms <= DUR_CLICK_MAX) begin
      cls = CLS_CLICK;
    end else if (duration_ms <= DUR_TAP_MAX) begin
      cls = CLS_TAP;
    end else if (duration_ms <= DUR_PULSE_MAX) begin
      cls = (amplitude >= AMP_HEAVY_MIN) ? CLS_HEAVY : CLS_PULSE;
    end else if (duration_ms <= DUR_SHORT_MAX) begin
      cls = CLS_SHORT;
    end else begin
      cls = CLS_LONG;
    end
    // overrides
    if (duration_ms <= DUR_DOUBLE_MAX && amplitude >= AMP_DOUBLE_MIN) cls = CLS_DOUBLE;
    if (duration_ms >= DUR_WARN_MIN && amplitude >= AMP_WARN_MIN) cls = CLS_WARNING;
    if (duration_ms == 16'd0 || amplitude == 8'd0) cls = CLS_NONE;
  end

  assign cmd_cls.cls = cls;
  assign cmd_cls.str = str;

endmodule

>>> rtl/core/hes_checker.sv
`include "haptic_effect_sequencer_defines.svh"

module hes_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [7:0]          out_motor_duty,
  input logic                out_playing,
  input logic [3:0]          out_effect_class,
  input logic [1:0]          out_strength_level
);
  import hes_pkg::*;

  // stalled result holds
  `HES_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_motor_duty) && $stable(out_playing) && $stable(out_effect_class) && $stable(out_strength_level), "result changed while stalled")

  // motor is off whenever no pattern runs
  `HES_ASSERT_NOW(a_idle_off, out_valid && !out_playing, out_motor_duty == 8'd0, "motor driven while idle")

  // the no-effect pattern never drives the motor
  `HES_ASSERT_NOW(a_none_off, out_valid && out_effect_class == CLS_NONE, out_motor_duty == 8'd0, "motor driven for no effect")

  // class and strength codes stay in range
  `HES_ASSERT_NOW(a_codes, out_valid, out_effect_class <= CLS_WARNING && out_strength_level != 2'd3, "class or strength out of range")

endmodule

bind haptic_effect_sequencer hes_checker u_hes_checker (.*);

>>> tb/tb_haptic_effect_sequencer.sv
// Self-checking bench for the haptic effect sequencer.
// A local model of the sequencer predicts one result per input transfer.
// Each result transfer is checked against the oldest prediction.
// The sender works in random bursts and the receiver stalls on its own schedule.
module tb_haptic_effect_sequencer;
  import hes_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SEQ_STEP_LIMIT = STEP_LIMIT_DEF;
  localparam int          RANDOM_ITEMS   = 650;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  // Index 3 is not mapped; the block must ignore writes to it.
  localparam reg_idx_t    REG_UNUSED     = 2'd3;

  typedef struct packed {
    duty_t motor_duty;
    logic  playing;
    cls_t  effect_class;
    str_t  strength_level;
  } hes_result_t;

  // ---------------------------------------------------------------------------
  // DUT ports. Every input is known from time zero.
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = 1'b0;
  logic [7:0]  in_amplitude = '0;
  logic [15:0] in_duration_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_motor_duty;
  logic        out_playing;
  logic [3:0]  out_effect_class;
  logic [1:0]  out_strength_level;
  logic        cfg_we = 1'b0;
  reg_idx_t    cfg_index = REG_DUTY_LOW;
  logic [7:0]  cfg_wdata = '0;

  haptic_effect_sequencer #(
    .STEP_LIMIT(SEQ_STEP_LIMIT)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_amplitude      (in_amplitude),
    .in_duration_ms    (in_duration_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_motor_duty    (out_motor_duty),
    .out_playing       (out_playing),
    .out_effect_class  (out_effect_class),
    .out_strength_level(out_strength_level),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Sequencer model state. It mirrors the register file and the pattern player.
  // ---------------------------------------------------------------------------
  duty_t       lvl_duty_low  = DUTY_LOW_RST;
  duty_t       lvl_duty_med  = DUTY_MED_RST;
  duty_t       lvl_duty_hi   = DUTY_HI_RST;
  cls_t        play_cls      = CLS_NONE;
  str_t        play_str      = STR_LOW;
  int          play_pos      = 0;
  int          play_ms       = 0;
  logic        play_on       = 1'b0;
  duty_t       play_duty     = '0;

  hes_result_t duty_pred_q[$];   // predicted results, oldest first
  hes_result_t chk_pred;

  int          fail_cnt      = 0;
  int          results_seen  = 0;
  int          n_cmds        = 0;
  int          n_ticks       = 0;
  int          n_writes      = 0;
  int          n_finished    = 0;
  int          burst_left    = 0;
  int unsigned cyc_cnt       = 0;

  // Pattern ROM, kept locally: number of steps, step length, step duty.
  function automatic int pattern_steps(cls_t c);
    int n;
    if (c == CLS_DOUBLE) n = 4;
    else if (c == CLS_WARNING) n = 6;
    else if (c >= CLS_CLICK && c <= CLS_LONG) n = 2;
    else n = 1;
    return (n > SEQ_STEP_LIMIT) ? SEQ_STEP_LIMIT : n;
  endfunction

  function automatic int step_len(cls_t c, int p);
    int t;
    case (c)
      CLS_CLICK:   t = (p == 0) ? 25 : 40;
      CLS_TAP:     t = 50;
      CLS_PULSE:   t = (p == 0) ? 90 : 60;
      CLS_HEAVY:   t = (p == 0) ? 120 : 70;
      CLS_SHORT:   t = (p == 0) ? 170 : 80;
      CLS_LONG:    t = (p == 0) ? 320 : 100;
      CLS_DOUBLE:  t = (p % 2 == 0) ? 25 : ((p == 1) ? 70 : 80);
      CLS_WARNING: t = (p % 2 == 0) ? 120 : ((p == 5) ? 100 : 70);
      default:     t = 1;
    endcase
    return t;
  endfunction

  function automatic duty_t step_level(cls_t c, int p, str_t s);
    src_t src;
    src = SRC_ZERO;
    if (p == 0) begin
      case (c)
        CLS_CLICK, CLS_TAP, CLS_SHORT, CLS_LONG: src = SRC_STR;
        CLS_PULSE:                               src = SRC_MED;
        CLS_HEAVY, CLS_DOUBLE, CLS_WARNING:      src = SRC_HIGH;
        default:                                 src = SRC_ZERO;
      endcase
    end else if (p % 2 == 0 && (c == CLS_DOUBLE || c == CLS_WARNING)) begin
      src = SRC_HIGH;
    end
    case (src)
      SRC_STR:  return (s == STR_LOW) ? lvl_duty_low :
                       (s == STR_HIGH) ? lvl_duty_hi : lvl_duty_med;
      SRC_MED:  return lvl_duty_med;
      SRC_HIGH: return lvl_duty_hi;
      default:  return '0;
    endcase
  endfunction

  // Total pattern length in ticks.
  function automatic int pattern_span(cls_t c);
    int sum;
    sum = 0;
    for (int p = 0; p < pattern_steps(c); p++) sum += step_len(c, p);
    return sum;
  endfunction

  function automatic cls_t effect_of(logic [7:0] amp, logic [15:0] dur);
    cls_t c;
    if (dur == 0 || amp == 0) return CLS_NONE;
    if (dur <= 30) c = CLS_CLICK;
    else if (dur <= 65) c = CLS_TAP;
    else if (dur <= 120) c = (amp >= 180) ? CLS_HEAVY : CLS_PULSE;
    else if (dur <= 220) c = CLS_SHORT;
    else c = CLS_LONG;
    if (dur <= 45 && amp >= 220) c = CLS_DOUBLE;
    if (dur >= 350 && amp >= 200) c = CLS_WARNING;
    return c;
  endfunction

  // Advance the model by one accepted item and queue the result it causes.
  task automatic advance_player(logic act, logic [7:0] amp, logic [15:0] dur);
    int next;
    if (act) begin
      play_str  = (amp < 85) ? STR_LOW : (amp < 170) ? STR_MED : STR_HIGH;
      play_cls  = effect_of(amp, dur);
      play_on   = 1'b1;
      play_pos  = 0;
      play_ms   = 0;
      play_duty = step_level(play_cls, 0, play_str);
      n_cmds++;
    end else begin
      n_ticks++;
      if (play_on) begin
        if (play_ms < ELAPSED_MAX) play_ms++;
        if (play_ms >= step_len(play_cls, play_pos)) begin
          next = play_pos + 1;
          if (next >= pattern_steps(play_cls)) begin
            play_on   = 1'b0;
            play_pos  = 0;
            play_ms   = 0;
            play_duty = '0;
            n_finished++;
          end else begin
            play_pos  = next;
            play_ms   = 0;
            play_duty = step_level(play_cls, play_pos, play_str);
          end
        end
      end
    end
    duty_pred_q.push_back('{play_duty, play_on, play_cls, play_str});
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one input transfer, with burst/gap pacing. Valid is lowered only
  // at the start of a gap or in drain(), so back-to-back items keep it high.
  // ---------------------------------------------------------------------------
  task automatic push_item(logic act, logic [7:0] amp, logic [15:0] dur);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // Mostly short bursts, sometimes a long stretch without gaps.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_action      <= act;
    in_amplitude   <= amp;
    in_duration_ms <= dur;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Transfer happened at this edge.
    advance_player(act, amp, dur);
  endtask

  // Stop sending and let every predicted result come out, plus pipeline slack.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (duty_pred_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write; only called after drain(), so no item is in flight.
  task automatic write_reg(reg_idx_t idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DUTY_LOW: lvl_duty_low = val;
      REG_DUTY_MED: lvl_duty_med = val;
      REG_DUTY_HI:  lvl_duty_hi  = val;
      default: ;
    endcase
    n_writes++;
    @(posedge clk);
  endtask

  task automatic write_all(logic [7:0] lo, logic [7:0] med, logic [7:0] hi);
    write_reg(REG_DUTY_LOW, lo);
    write_reg(REG_DUTY_MED, med);
    write_reg(REG_DUTY_HI, hi);
  endtask

  // Random command aimed at a given class. The model classifies it on its own.
  task automatic aim_command(cls_t c, output logic [7:0] amp, output logic [15:0] dur);
    int d;
    case (c)
      CLS_NONE: begin
        if ($urandom_range(0, 1)) begin
          amp = 8'($urandom);
          dur = '0;
        end else begin
          amp = '0;
          dur = 16'($urandom);
        end
      end
      CLS_CLICK: begin
        dur = 16'($urandom_range(1, 30));
        amp = 8'($urandom_range(1, 219));
      end
      CLS_TAP: begin
        d   = $urandom_range(31, 65);
        dur = 16'(d);
        amp = (d <= 45) ? 8'($urandom_range(1, 219)) : 8'($urandom_range(1, 255));
      end
      CLS_PULSE: begin
        dur = 16'($urandom_range(66, 120));
        amp = 8'($urandom_range(1, 179));
      end
      CLS_HEAVY: begin
        dur = 16'($urandom_range(66, 120));
        amp = 8'($urandom_range(180, 255));
      end
      CLS_SHORT: begin
        dur = 16'($urandom_range(121, 220));
        amp = 8'($urandom_range(1, 255));
      end
      CLS_LONG: begin
        if ($urandom_range(0, 1)) begin
          dur = 16'($urandom_range(221, 349));
          amp = 8'($urandom_range(1, 255));
        end else begin
          dur = 16'($urandom_range(350, 65535));
          amp = 8'($urandom_range(1, 199));
        end
      end
      CLS_DOUBLE: begin
        dur = 16'($urandom_range(1, 45));
        amp = 8'($urandom_range(220, 255));
      end
      default: begin
        dur = 16'($urandom_range(350, 65535));
        amp = 8'($urandom_range(200, 255));
      end
    endcase
  endtask

  // Start a pattern of the given class and tick it to the end, then idle a bit.
  task automatic play_out(cls_t c);
    logic [7:0]  amp;
    logic [15:0] dur;
    aim_command(c, amp, dur);
    push_item(1'b1, amp, dur);
    repeat (pattern_span(c) + 2) push_item(1'b0, 8'($urandom), 16'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every class threshold from both sides, idle ticks, none class.
  task automatic test_thresholds();
    push_item(1'b0, 8'hFF, 16'hFFFF);   // tick while idle
    push_item(1'b1, 8'd0, 16'd0);       // none class, low strength
    push_item(1'b0, 8'd0, 16'd0);       // one-step none pattern ends
    push_item(1'b1, 8'd255, 16'd0);     // none class, high strength
    push_item(1'b1, 8'd0, 16'hFFFF);    // none again, cancels the previous one
    push_item(1'b1, 8'd255, 16'hFFFF);  // warning at max fields
    push_item(1'b0, 8'h55, 16'hAAAA);
    push_item(1'b1, 8'd84, 16'd30);     // click, top of low strength
    push_item(1'b1, 8'd85, 16'd31);     // tap, bottom of medium
    push_item(1'b1, 8'd169, 16'd65);    // tap, top of medium
    push_item(1'b1, 8'd170, 16'd66);    // pulse, bottom of high
    push_item(1'b1, 8'd179, 16'd120);   // pulse, just below heavy
    push_item(1'b1, 8'd180, 16'd120);   // heavy
    push_item(1'b1, 8'd255, 16'd121);   // short
    push_item(1'b1, 8'd1, 16'd220);     // short, minimum amplitude
    push_item(1'b1, 8'd1, 16'd221);     // long
    push_item(1'b1, 8'd219, 16'd45);    // just misses double
    push_item(1'b1, 8'd220, 16'd45);    // double override
    push_item(1'b1, 8'd220, 16'd46);    // past double duration
    push_item(1'b1, 8'd200, 16'd350);   // warning override
    push_item(1'b1, 8'd199, 16'd350);   // just misses warning
    push_item(1'b1, 8'd200, 16'd349);   // just misses warning on duration
    push_item(1'b1, 8'd1, 16'd1);       // smallest click
    push_item(1'b0, 8'hAA, 16'h5555);
    drain();
  endtask

  // Every class played to completion under reset, all-zero, all-max and random
  // duty settings; one register change lands in the middle of a warning.
  task automatic test_pattern_playback();
    int first;
    play_out(CLS_NONE);
    play_out(CLS_CLICK);
    play_out(CLS_TAP);
    drain();
    write_all(8'd0, 8'd0, 8'd0);
    play_out(CLS_CLICK);
    play_out(CLS_PULSE);
    play_out(CLS_HEAVY);
    drain();
    write_all(8'd255, 8'd255, 8'd255);
    play_out(CLS_SHORT);
    play_out(CLS_DOUBLE);
    drain();
    write_all(8'($urandom), 8'($urandom), 8'($urandom));
    play_out(CLS_LONG);
    // Warning with a high duty change during its first step: steps that start
    // later pick up the new value, the running one keeps the old.
    first = 60;
    push_item(1'b1, 8'd230, 16'd1000);
    repeat (first) push_item(1'b0, 8'($urandom), 16'($urandom));
    drain();
    write_reg(REG_DUTY_HI, 8'($urandom));
    write_reg(REG_UNUSED, 8'($urandom));
    repeat (pattern_span(CLS_WARNING) - first + 2) push_item(1'b0, 8'($urandom), 16'($urandom));
    drain();
  endtask

  // Mostly well-formed command + tick sequences, some cut short by the next
  // command, some raw noise, and occasional register changes between them.
  task automatic test_random_sequences();
    int          sent;
    int          pick;
    int          span;
    int          ticks;
    int          roll;
    cls_t        c;
    logic [7:0]  amp;
    logic [15:0] dur;
    logic [7:0]  val;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5)) begin
          push_item(1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom));
          sent++;
        end
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10) c = CLS_NONE;
        else if (pick < 30) c = CLS_CLICK;
        else if (pick < 45) c = CLS_TAP;
        else if (pick < 55) c = CLS_PULSE;
        else if (pick < 63) c = CLS_HEAVY;
        else if (pick < 70) c = CLS_SHORT;
        else if (pick < 75) c = CLS_LONG;
        else if (pick < 92) c = CLS_DOUBLE;
        else c = CLS_WARNING;
        aim_command(c, amp, dur);
        push_item(1'b1, amp, dur);
        sent++;
        span = pattern_span(c);
        roll = $urandom_range(0, 9);
        // Long patterns are mostly cut short to keep the run bounded.
        if (roll < 6 && (span <= 250 || roll < 1)) ticks = span + $urandom_range(0, 3);
        else ticks = $urandom_range(0, span);
        repeat (ticks) begin
          push_item(1'b0, 8'($urandom), 16'($urandom));
          sent++;
        end
      end
      if ($urandom_range(0, 7) == 0) begin
        drain();
        case ($urandom_range(0, 3))
          0:       val = 8'd0;
          1:       val = 8'd255;
          default: val = 8'($urandom);
        endcase
        write_reg(($urandom_range(0, 15) == 0) ? REG_UNUSED : reg_idx_t'($urandom_range(0, 2)),
                  val);
      end
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall pattern: four modes selected by cyc_cnt[9:8], from always
  // ready through random and periodic stalls.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    case (cyc_cnt[9:8])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready <= (cyc_cnt[3:0] > 4'd4);
      default: out_ready <= 1'($urandom_range(0, 1));
    endcase
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("haptic_effect_sequencer: mismatch");
      $finish;
    end
  end

  // Result checker: every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (duty_pred_q.size() == 0) begin
        $error("result transfer with no prediction pending");
        fail_cnt++;
      end else begin
        chk_pred = duty_pred_q.pop_front();
        results_seen++;
        if (out_motor_duty !== chk_pred.motor_duty) begin
          $error("motor_duty: expected %0d, got %0d", chk_pred.motor_duty, out_motor_duty);
          fail_cnt++;
        end
        if (out_playing !== chk_pred.playing) begin
          $error("playing: expected %0d, got %0d", chk_pred.playing, out_playing);
          fail_cnt++;
        end
        if (out_effect_class !== chk_pred.effect_class) begin
          $error("effect_class: expected %0d, got %0d", chk_pred.effect_class,
                 out_effect_class);
          fail_cnt++;
        end
        if (out_strength_level !== chk_pred.strength_level) begin
          $error("strength_level: expected %0d, got %0d", chk_pred.strength_level,
                 out_strength_level);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_thresholds();
    test_pattern_playback();
    test_random_sequences();

    // All predictions drained inside the tests; allow trailing slack so a
    // stray extra result would still be caught.
    while (duty_pred_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d commands and %0d ticks; %0d results checked, %0d patterns ran out",
             n_cmds, n_ticks, results_seen, n_finished);
    $display("Duty registers written %0d times over reset, zero, max and random settings",
             n_writes);
    if (fail_cnt == 0 && duty_pred_q.size() == 0) begin
      $display("haptic_effect_sequencer: match");
    end else begin
      $display("haptic_effect_sequencer: mismatch");
    end
    $finish;
  end

endmodule
